[rtl/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, constants and lookup functions of the synth patch register
// store: command beats between front and back end, output beats, the
// sequencer states, the default patch and the mode scaling table.
// ----------------------------------------------------------------------------
package spr_pkg;

    // widest patch index over the parameter range (128 banks x 128 programs)
    localparam int IDX_MAX_W      = 14;
    localparam int NUM_OPERATORS  = 8;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

    // request kinds on the input tuser
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_DEFINE = 2'd2;

    // patch byte map
    localparam logic [6:0] ADDR_FREQ_LO   = 7'h02;
    localparam logic [6:0] ADDR_MODE      = 7'h1C;
    localparam logic [6:0] ADDR_FEEDBACK  = 7'h1F;
    localparam logic [6:0] ADDR_KEY_SHIFT = 7'h40;
    localparam logic [5:0] IMG_MODE       = 6'h1C;
    localparam logic [5:0] IMG_RSVD_A     = 6'h1D;
    localparam logic [5:0] IMG_RSVD_B     = 6'h1E;
    localparam logic [5:0] IMG_FREQ_HI0   = 6'h00;
    localparam logic [5:0] IMG_FREQ_LO0   = 6'h01;
    localparam logic [2:0] IMG_VOL_GROUP  = 3'b010;
    localparam logic [5:0] IMG_LAST       = 6'h3F;

    localparam logic [7:0] DEFAULT_MODE      = 8'd4;
    localparam logic [7:0] DEFAULT_KEY_SHIFT = 8'd0;

    typedef enum logic [1:0] {
        CMD_WR_BYTE,
        CMD_WR_KEY,
        CMD_DEFINE,
        CMD_READ
    } spr_cmd_kind_t;

    typedef struct packed {
        spr_cmd_kind_t          kind;
        logic                   in_range;
        logic                   bank_nz;
        logic [IDX_MAX_W-1:0]   idx;
        logic [IDX_MAX_W-1:0]   alt_idx;
        logic [5:0]             byte_addr;
        logic [7:0]             value;
        logic [7:0]             volume;
    } spr_cmd_t;

    typedef struct packed {
        logic [7:0] key_shift;
        logic       last;
        logic [7:0] value;
        logic [5:0] addr;
    } spr_beat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK_SELF,
        ST_MARK_ALT,
        ST_MODE,
        ST_EMIT,
        ST_DRAIN
    } spr_state_t;

    // fixed default patch image
    function automatic logic [7:0] default_byte(input logic [5:0] a);
        logic [7:0] b;
        case (a)
            6'h02:        b = 8'h10;
            6'h10:        b = 8'hFF;
            6'h11:        b = 8'd17;
            6'h18:        b = 8'h36;
            6'h1C:        b = 8'd4;
            6'h1F:        b = 8'h80;
            6'h21:        b = 8'd64;
            6'h22:        b = 8'd1;
            6'h23:        b = 8'd32;
            6'h26, 6'h27: b = 8'hFF;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

    // operators whose volume follows midi volume, per mode
    function automatic logic [7:0] scale_mask(input logic [7:0] mode);
        logic [7:0] m;
        case (mode)
            8'd0:    m = 8'hFF;
            8'd1:    m = 8'h0F;
            8'd2:    m = 8'h0F;
            8'd3:    m = 8'h03;
            8'd4:    m = 8'h01;
            8'd5:    m = 8'h33;
            8'd6:    m = 8'h55;
            8'd7:    m = 8'h01;
            8'd8:    m = 8'h03;
            8'd9:    m = 8'h01;
            8'd10:   m = 8'h0F;
            8'd11:   m = 8'h03;
            8'd12:   m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

[rtl/spr_fifo.sv]
// ----------------------------------------------------------------------------
// spr_fifo
// Small synchronous fifo with occupancy count; depth is a power of two.
// ----------------------------------------------------------------------------
module spr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             pop_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = store_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/spr_front.sv]
// ----------------------------------------------------------------------------
// spr_front
// Input front end: range checks, patch index and byte classification.
// Beats that change nothing and produce nothing are dropped here.
// ----------------------------------------------------------------------------
module spr_front #(
    parameter int NUM_BANKS         = 4,
    parameter int PROGRAMS_PER_BANK = 128
) (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              clearing,
    input  logic              cmd_full,
    output logic              cmd_push,
    output spr_pkg::spr_cmd_t cmd_data
);
    import spr_pkg::*;

    logic [1:0]  bank;
    logic [6:0]  prog;
    logic [6:0]  byte_addr;
    logic [7:0]  write_value;
    logic [7:0]  midi_volume;
    logic        in_range;
    logic        writable;
    logic        keep;
    logic [31:0] idx_full;

    assign bank        = s_tdata[1:0];
    assign prog        = s_tdata[8:2];
    assign byte_addr   = s_tdata[15:9];
    assign write_value = s_tdata[23:16];
    assign midi_volume = s_tdata[31:24];

    assign s_tready = !cmd_full && !clearing;

    // patch index and range
    always_comb begin
        in_range = (32'(bank) < 32'(NUM_BANKS)) && (32'(prog) < 32'(PROGRAMS_PER_BANK));
        idx_full = 32'(bank) * 32'(PROGRAMS_PER_BANK) + 32'(prog);
        writable = byte_addr inside {[ADDR_FREQ_LO:ADDR_MODE],
                                     [ADDR_FEEDBACK:ADDR_KEY_SHIFT]};
    end

    // classify the beat
    always_comb begin
        cmd_data.in_range  = in_range;
        cmd_data.bank_nz   = (bank != 2'd0);
        cmd_data.idx       = idx_full[IDX_MAX_W-1:0];
        cmd_data.alt_idx   = IDX_MAX_W'(prog);
        cmd_data.byte_addr = byte_addr[5:0];
        cmd_data.value     = write_value;
        cmd_data.volume    = midi_volume;
        cmd_data.kind      = CMD_READ;
        keep               = 1'b0;
        case (s_tuser)
            REQ_WRITE: begin
                keep          = in_range && writable;
                cmd_data.kind = (byte_addr == ADDR_KEY_SHIFT) ? CMD_WR_KEY : CMD_WR_BYTE;
            end
            REQ_READ: begin
                keep          = 1'b1;
                cmd_data.kind = CMD_READ;
            end
            REQ_DEFINE: begin
                keep          = in_range;
                cmd_data.kind = CMD_DEFINE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd_push = s_tvalid && s_tready && keep;

endmodule

[rtl/spr_back.sv]
// ----------------------------------------------------------------------------
// spr_back
// Back end: patch memories, defined-mark clearing pass, patch selection and
// the image read pipeline (memory read, multiply, divide by 255).
// ----------------------------------------------------------------------------
module spr_back #(
    parameter int NUM_BANKS         = 4,
    parameter int PROGRAMS_PER_BANK = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  spr_pkg::spr_cmd_t               cmd,
    output logic                            cmd_pop,
    input  logic [spr_pkg::OUT_CNT_W-1:0]   out_count,
    output logic                            out_push,
    output spr_pkg::spr_beat_t              out_data,
    output logic                            clearing
);
    import spr_pkg::*;

    localparam int NUM_PATCHES = NUM_BANKS * PROGRAMS_PER_BANK;
    localparam int IDX_W       = (NUM_PATCHES > 1) ? $clog2(NUM_PATCHES) : 1;
    localparam int MAIN_DEPTH  = NUM_PATCHES * 64;
    localparam int MAIN_AW     = IDX_W + 6;
    localparam int ROOM_W      = OUT_CNT_W + 2;

    // memories
    logic [7:0] main_mem [MAIN_DEPTH];
    logic [7:0] key_mem  [NUM_PATCHES];
    logic       mark_mem [NUM_PATCHES];

    logic               main_we, main_re;
    logic [MAIN_AW-1:0] main_waddr, main_raddr;
    logic [7:0]         main_rd_reg;
    logic               key_we, key_re;
    logic [IDX_W-1:0]   key_waddr, key_raddr;
    logic [7:0]         key_rd_reg;
    logic               mark_we, mark_re, mark_wdata;
    logic [IDX_W-1:0]   mark_waddr, mark_raddr;
    logic               mark_rd_reg;

    // sequencer
    spr_state_t       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic [IDX_W-1:0] cur_alt_reg, cur_alt_next;
    logic             cur_bank_nz_reg, cur_bank_nz_next;
    logic [IDX_W-1:0] src_idx_reg, src_idx_next;
    logic             use_dflt_reg, use_dflt_next;
    logic [7:0]       mask_reg, mask_next;
    logic [7:0]       key_reg, key_next;
    logic [7:0]       vol_reg, vol_next;
    logic [5:0]       emit_cnt_reg, emit_cnt_next;
    logic             room;
    logic [7:0]       mode_byte;

    // pipeline
    logic        s1_valid_reg, s1_valid_next;
    logic [5:0]  s1_addr_reg;
    logic        s1_dflt_reg;
    logic        s2_valid_reg;
    logic [5:0]  s2_addr_reg;
    logic [7:0]  s2_raw_reg;
    logic [15:0] s2_prod_reg;
    logic        s2_scale_reg;
    logic [7:0]  s1_raw;
    logic        s1_scale;
    logic [16:0] div_sum;

    assign clearing = (state_reg == ST_CLEAR);

    // output fifo room for one more beat beyond those in flight
    assign room = (ROOM_W'(out_count) + ROOM_W'(s1_valid_reg) + ROOM_W'(s2_valid_reg))
                  < ROOM_W'(OUT_FIFO_DEPTH);

    assign mode_byte = use_dflt_reg ? DEFAULT_MODE : main_rd_reg;

    // next state and memory controls
    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cur_idx_next     = cur_idx_reg;
        cur_alt_next     = cur_alt_reg;
        cur_bank_nz_next = cur_bank_nz_reg;
        src_idx_next     = src_idx_reg;
        use_dflt_next    = use_dflt_reg;
        mask_next        = mask_reg;
        key_next         = key_reg;
        vol_next         = vol_reg;
        emit_cnt_next    = emit_cnt_reg;
        s1_valid_next    = 1'b0;
        cmd_pop          = 1'b0;
        main_we          = 1'b0;
        main_waddr       = {cmd.idx[IDX_W-1:0], cmd.byte_addr};
        main_re          = 1'b0;
        main_raddr       = {src_idx_reg, emit_cnt_reg};
        key_we           = 1'b0;
        key_waddr        = cmd.idx[IDX_W-1:0];
        key_re           = 1'b0;
        key_raddr        = src_idx_reg;
        mark_we          = 1'b0;
        mark_waddr       = cmd.idx[IDX_W-1:0];
        mark_wdata       = cmd.value[0];
        mark_re          = 1'b0;
        mark_raddr       = cmd.idx[IDX_W-1:0];
        case (state_reg)
            ST_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = clr_cnt_reg;
                mark_wdata = 1'b0;
                if (clr_cnt_reg == IDX_W'(NUM_PATCHES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_WR_BYTE: main_we = 1'b1;
                        CMD_WR_KEY:  key_we  = 1'b1;
                        CMD_DEFINE:  mark_we = 1'b1;
                        CMD_READ: begin
                            vol_next         = cmd.volume;
                            cur_idx_next     = cmd.idx[IDX_W-1:0];
                            cur_alt_next     = cmd.alt_idx[IDX_W-1:0];
                            cur_bank_nz_next = cmd.bank_nz;
                            if (cmd.in_range) begin
                                mark_re    = 1'b1;
                                state_next = ST_MARK_SELF;
                            end else begin
                                use_dflt_next = 1'b1;
                                state_next    = ST_MODE;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MARK_SELF: begin
                if (mark_rd_reg) begin
                    use_dflt_next = 1'b0;
                    src_idx_next  = cur_idx_reg;
                    main_re       = 1'b1;
                    main_raddr    = {cur_idx_reg, IMG_MODE};
                    key_re        = 1'b1;
                    key_raddr     = cur_idx_reg;
                    state_next    = ST_MODE;
                end else if (cur_bank_nz_reg) begin
                    mark_re    = 1'b1;
                    mark_raddr = cur_alt_reg;
                    state_next = ST_MARK_ALT;
                end else begin
                    use_dflt_next = 1'b1;
                    state_next    = ST_MODE;
                end
            end
            ST_MARK_ALT: begin
                if (mark_rd_reg) begin
                    use_dflt_next = 1'b0;
                    src_idx_next  = cur_alt_reg;
                    main_re       = 1'b1;
                    main_raddr    = {cur_alt_reg, IMG_MODE};
                    key_re        = 1'b1;
                    key_raddr     = cur_alt_reg;
                end else begin
                    use_dflt_next = 1'b1;
                end
                state_next = ST_MODE;
            end
            ST_MODE: begin
                mask_next     = scale_mask(mode_byte);
                key_next      = use_dflt_reg ? DEFAULT_KEY_SHIFT : key_rd_reg;
                emit_cnt_next = '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (room) begin
                    s1_valid_next = 1'b1;
                    main_re       = !use_dflt_reg;
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                    if (emit_cnt_reg == IMG_LAST) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // read context
    always_ff @(posedge aclk) begin
        cur_idx_reg     <= cur_idx_next;
        cur_alt_reg     <= cur_alt_next;
        cur_bank_nz_reg <= cur_bank_nz_next;
        src_idx_reg     <= src_idx_next;
        use_dflt_reg    <= use_dflt_next;
        mask_reg        <= mask_next;
        key_reg         <= key_next;
        vol_reg         <= vol_next;
        emit_cnt_reg    <= emit_cnt_next;
    end

    // patch byte memory
    always_ff @(posedge aclk) begin
        if (main_we) begin
            main_mem[main_waddr] <= cmd.value;
        end
        if (main_re) begin
            main_rd_reg <= main_mem[main_raddr];
        end
    end

    // key shift memory
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= cmd.value;
        end
        if (key_re) begin
            key_rd_reg <= key_mem[key_raddr];
        end
    end

    // defined marks
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (mark_re) begin
            mark_rd_reg <= mark_mem[mark_raddr];
        end
    end

    // stage one tags travel with the memory read
    always_ff @(posedge aclk) begin
        s1_addr_reg <= emit_cnt_reg;
        s1_dflt_reg <= use_dflt_reg;
    end

    // pick the image byte, reserved bytes and image bytes 0 and 1 read as zero
    always_comb begin
        if (s1_addr_reg == IMG_FREQ_HI0 || s1_addr_reg == IMG_FREQ_LO0 ||
            s1_addr_reg == IMG_RSVD_A || s1_addr_reg == IMG_RSVD_B) begin
            s1_raw = 8'h00;
        end else if (s1_dflt_reg) begin
            s1_raw = default_byte(s1_addr_reg);
        end else begin
            s1_raw = main_rd_reg;
        end
        s1_scale = (s1_addr_reg[5:3] == IMG_VOL_GROUP) && mask_reg[s1_addr_reg[2:0]];
    end

    // stage two: volume product
    always_ff @(posedge aclk) begin
        s2_addr_reg  <= s1_addr_reg;
        s2_raw_reg   <= s1_raw;
        s2_scale_reg <= s1_scale;
        s2_prod_reg  <= 16'(s1_raw) * 16'(vol_reg);
    end

    // divide by 255: (p + p/256 + 1) / 256 is exact for 16-bit products
    assign div_sum = 17'(s2_prod_reg) + 17'(s2_prod_reg[15:8]) + 17'd1;

    always_comb begin
        out_push           = s2_valid_reg;
        out_data.addr      = s2_addr_reg;
        out_data.value     = s2_scale_reg ? div_sum[15:8] : s2_raw_reg;
        out_data.last      = (s2_addr_reg == IMG_LAST);
        out_data.key_shift = key_reg;
    end

endmodule

[rtl/synth_patch_register_store_top.sv]
// ----------------------------------------------------------------------------
// synth_patch_register_store_top
// Patch store for an eight-operator synth: byte writes, defined marks and
// 64-byte register image reads with midi volume scaling.
// ----------------------------------------------------------------------------
// Usage:
// - s_ channel takes requests; tuser holds the request kind (write byte,
//   read image, set defined mark), tdata the bank, program, byte address,
//   write value and midi volume.
// - m_ channel returns register image beats, 64 per read, in address order;
//   tlast marks the beat at address 63. Writes and defines return nothing.
// - Writes and defines are taken by the back end in its idle state. A read
//   picks up the command, makes up to two defined-mark lookups and a mode
//   fetch, issues one image byte per cycle while the output fifo has room
//   from the single read port of the patch memory, then drains its pipeline
//   (memory read, volume product) before the next command is taken.
// - A two-entry command queue lets requests be taken while a read streams.
// - After reset the defined marks are cleared one entry per cycle, all
//   NUM_BANKS * PROGRAMS_PER_BANK of them (512 by default); s_tready stays
//   low during that pass. Patch bytes are not cleared.
// - When m_tready is low, the image sequencer pauses once the beats in its
//   four-entry output fifo and those in flight would fill it; no beat is lost.
// ----------------------------------------------------------------------------
module synth_patch_register_store_top #(
    parameter int NUM_BANKS         = 4,
    parameter int PROGRAMS_PER_BANK = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bank, program_req, byte_addr, write_value, midi_volume
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // reg_addr, reg_value, key_shift, zero pad
    output logic        m_tlast    // last
);
    import spr_pkg::*;

    localparam int CMD_W  = $bits(spr_cmd_t);
    localparam int BEAT_W = $bits(spr_beat_t);

    spr_cmd_t               cmd_push_data;
    spr_cmd_t               cmd_pop_data;
    logic                   cmd_push, cmd_pop, cmd_full, cmd_empty;
    logic [$clog2(CMD_FIFO_DEPTH+1)-1:0] cmd_count;
    spr_beat_t              out_push_data;
    spr_beat_t              out_pop_data;
    logic                   out_push, out_pop, out_full, out_empty;
    logic [OUT_CNT_W-1:0]   out_count;
    logic                   clearing;

    // request classification
    spr_front #(
        .NUM_BANKS         (NUM_BANKS),
        .PROGRAMS_PER_BANK (PROGRAMS_PER_BANK)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_push_data)
    );

    // command queue between front and back end
    spr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_push_data),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_pop_data),
        .empty     (cmd_empty),
        .count     (cmd_count)
    );

    // memories and image sequencer
    spr_back #(
        .NUM_BANKS         (NUM_BANKS),
        .PROGRAMS_PER_BANK (PROGRAMS_PER_BANK)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_pop_data),
        .cmd_pop   (cmd_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (out_push_data),
        .clearing  (clearing)
    );

    // output beat buffer
    spr_fifo #(
        .WIDTH (BEAT_W),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .push_data (out_push_data),
        .full      (out_full),
        .pop       (out_pop),
        .pop_data  (out_pop_data),
        .empty     (out_empty),
        .count     (out_count)
    );

    assign m_tvalid = !out_empty;
    assign out_pop  = m_tvalid && m_tready;
    assign m_tdata  = {2'b00, out_pop_data.key_shift, out_pop_data.value, out_pop_data.addr};
    assign m_tlast  = out_pop_data.last;

    // checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> !out_full)
        else $error("output fifo overflow");

    a_no_cmd_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push |-> (cmd_count < ($clog2(CMD_FIFO_DEPTH+1))'(CMD_FIFO_DEPTH)))
        else $error("command queue overflow");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> (!s_tready && !m_tvalid))
        else $error("traffic during mark clearing");

    a_last_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] == IMG_LAST))
        else $error("tlast on wrong image address");

endmodule
